/* hw/rtl/tfrl_pkg.sv */
// tfrl_pkg: shared types and constants of the throttle ramp limiter
// register indexes, reset values and the configuration bundle
// no dependencies
package tfrl_pkg;

  // configuration port geometry
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // speed, duty and rate words
  localparam int WORD_W = 16;
  localparam int MS_W   = 10;
  localparam int PROD_W = 2 * WORD_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_FLOOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_CEILING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_FLOOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_GAIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_RATE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_RATE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT    = 3'd7;

  // reset values (angle values are cut to the angle width on use)
  localparam logic [WORD_W-1:0] RST_JUMP_LIMIT    = 16'd1000;
  localparam logic [WORD_W-1:0] RST_ANGLE_FLOOR   = 16'd400;
  localparam logic [WORD_W-1:0] RST_ANGLE_CEILING = 16'd3800;
  localparam logic [WORD_W-1:0] RST_SPEED_FLOOR   = 16'd6554;
  localparam logic [WORD_W-1:0] RST_MAP_GAIN      = 16'd4441;
  localparam logic [WORD_W-1:0] RST_RISE_RATE     = 16'd5592;
  localparam logic [WORD_W-1:0] RST_FALL_RATE     = 16'd33554;
  localparam logic [WORD_W-1:0] RST_DUTY_LIMIT    = 16'd62258;

  // register contents; angle fields are zero-extended to the word width
  typedef struct packed {
    logic [WORD_W-1:0] jump_limit;
    logic [WORD_W-1:0] angle_floor;
    logic [WORD_W-1:0] angle_ceiling;
    logic [WORD_W-1:0] speed_floor;
    logic [WORD_W-1:0] map_gain;
    logic [WORD_W-1:0] rise_rate;
    logic [WORD_W-1:0] fall_rate;
    logic [WORD_W-1:0] duty_limit;
  } cfg_t;

endpackage

/* hw/rtl/tfrl_in_if.sv */
// tfrl_in_if: input channel of the throttle ramp limiter, one item per tick
// valid/ready handshake with the tick fields; no dependencies
interface tfrl_in_if #(
  parameter int ANGLE_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] angle;
  logic                  trigger_held;
  logic                  output_off;
  logic                  fault_active;
  logic [9:0]            elapsed_ms;

  modport source (
    output valid, angle, trigger_held, output_off, fault_active, elapsed_ms,
    input  ready
  );
  modport sink (
    input  valid, angle, trigger_held, output_off, fault_active, elapsed_ms,
    output ready
  );
endinterface

/* hw/rtl/tfrl_out_if.sv */
// tfrl_out_if: result channel of the throttle ramp limiter
// valid/ready handshake carrying the Q0.16 duty; no dependencies
interface tfrl_out_if ();
  logic        valid;
  logic        ready;
  logic [15:0] duty;

  modport source (output valid, duty, input ready);
  modport sink (input valid, duty, output ready);
endinterface

/* hw/rtl/tfrl_cfg.sv */
// tfrl_cfg: configuration register bank with write decode
// depends on tfrl_pkg
module tfrl_cfg #(
  parameter int ANGLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tfrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfrl_pkg::CFG_DATA_W-1:0] cfg_data,
  output tfrl_pkg::cfg_t                regs
);

  logic [ANGLE_BITS-1:0]          jump_limit;
  logic [ANGLE_BITS-1:0]          angle_floor;
  logic [ANGLE_BITS-1:0]          angle_ceiling;
  logic [tfrl_pkg::WORD_W-1:0]    speed_floor;
  logic [tfrl_pkg::WORD_W-1:0]    map_gain;
  logic [tfrl_pkg::WORD_W-1:0]    rise_rate;
  logic [tfrl_pkg::WORD_W-1:0]    fall_rate;
  logic [tfrl_pkg::WORD_W-1:0]    duty_limit;

  // register writes, unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      jump_limit    <= tfrl_pkg::RST_JUMP_LIMIT[ANGLE_BITS-1:0];
      angle_floor   <= tfrl_pkg::RST_ANGLE_FLOOR[ANGLE_BITS-1:0];
      angle_ceiling <= tfrl_pkg::RST_ANGLE_CEILING[ANGLE_BITS-1:0];
      speed_floor   <= tfrl_pkg::RST_SPEED_FLOOR;
      map_gain      <= tfrl_pkg::RST_MAP_GAIN;
      rise_rate     <= tfrl_pkg::RST_RISE_RATE;
      fall_rate     <= tfrl_pkg::RST_FALL_RATE;
      duty_limit    <= tfrl_pkg::RST_DUTY_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        tfrl_pkg::REG_JUMP_LIMIT:    jump_limit    <= cfg_data[ANGLE_BITS-1:0];
        tfrl_pkg::REG_ANGLE_FLOOR:   angle_floor   <= cfg_data[ANGLE_BITS-1:0];
        tfrl_pkg::REG_ANGLE_CEILING: angle_ceiling <= cfg_data[ANGLE_BITS-1:0];
        tfrl_pkg::REG_SPEED_FLOOR:   speed_floor   <= cfg_data;
        tfrl_pkg::REG_MAP_GAIN:      map_gain      <= cfg_data;
        tfrl_pkg::REG_RISE_RATE:     rise_rate     <= cfg_data;
        tfrl_pkg::REG_FALL_RATE:     fall_rate     <= cfg_data;
        tfrl_pkg::REG_DUTY_LIMIT:    duty_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  // bundle out, angle fields widened
  always_comb begin
    regs.jump_limit    = tfrl_pkg::WORD_W'(jump_limit);
    regs.angle_floor   = tfrl_pkg::WORD_W'(angle_floor);
    regs.angle_ceiling = tfrl_pkg::WORD_W'(angle_ceiling);
    regs.speed_floor   = speed_floor;
    regs.map_gain      = map_gain;
    regs.rise_rate     = rise_rate;
    regs.fall_rate     = fall_rate;
    regs.duty_limit    = duty_limit;
  end

endmodule

/* hw/rtl/tfrl_mul.sv */
// tfrl_mul: shared 16x16 unsigned multiplier with registered product
// depends on tfrl_pkg
module tfrl_mul (
  input  logic                          clk,
  input  logic [tfrl_pkg::WORD_W-1:0]   op_a,
  input  logic [tfrl_pkg::WORD_W-1:0]   op_b,
  output logic [tfrl_pkg::PROD_W-1:0]   product
);

  // one product per cycle, registered for use in the next cycle
  always_ff @(posedge clk) begin
    product <= tfrl_pkg::PROD_W'(op_a) * tfrl_pkg::PROD_W'(op_b);
  end

endmodule

/* hw/rtl/throttle_filter_ramp_limiter_core.sv */
// throttle_filter_ramp_limiter_core: throttle jump filter, angle map and ramp limiter
// depends on tfrl_pkg, tfrl_in_if, tfrl_out_if, tfrl_cfg, tfrl_mul
//
//  channel | dir | handshake        | payload
//  tick    | in  | valid/ready      | angle, trigger_held, output_off, fault_active, elapsed_ms
//  cmd     | out | valid/ready      | duty (Q0.16)
//  cfg     | in  | cfg_we, no ready | cfg_index, cfg_data
//
// an active item passes the states JUMP, CLAMP, MAP, RATE, STEP, RAMP, DUTY and DONE
// on its way to a result in the output register; the next item is taken only back in IDLE
// one multiplier is shared by the angle map, the rate step and the duty scaling
// an item with output_off or fault_active set is dropped in its acceptance cycle
// tick.ready is high only while the sequencer is idle; a waiting result does not block
// acceptance, but the next result waits in the last step until cmd is free
// rst is synchronous and clears the sequencer, the held angle and the ramp speed
module throttle_filter_ramp_limiter_core #(
  parameter int ANGLE_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  tfrl_in_if.sink                         tick,
  tfrl_out_if.source                      cmd,
  input  logic                            cfg_we,
  input  logic [tfrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfrl_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int W = tfrl_pkg::WORD_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_JUMP  = 9'b000000010,
    S_CLAMP = 9'b000000100,
    S_MAP   = 9'b000001000,
    S_RATE  = 9'b000010000,
    S_STEP  = 9'b000100000,
    S_RAMP  = 9'b001000000,
    S_DUTY  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;

  tfrl_pkg::cfg_t regs;

  logic [ANGLE_BITS-1:0]          angle_q;
  logic                           trig_q;
  logic [tfrl_pkg::MS_W-1:0]      ms_q;
  logic [ANGLE_BITS-1:0]          held_angle;
  logic                           angle_seen;
  logic [ANGLE_BITS-1:0]          angle_sel;
  logic [ANGLE_BITS-1:0]          span;
  logic [W-1:0]                   target;
  logic [W-1:0]                   step;
  logic [W-1:0]                   ramp_speed;
  logic                           out_valid;
  logic [W-1:0]                   out_duty;

  logic [W-1:0]                   op_a, op_b;
  logic [tfrl_pkg::PROD_W-1:0]    product;

  logic                           in_fire;
  logic                           in_active;
  logic                           out_free;

  logic [ANGLE_BITS-1:0]          jl, af, ac;
  logic [ANGLE_BITS-1:0]          ref_angle, diff, clamp_hi, clamp_lo;
  logic [24:0]                    map_sum;
  logic [W-1:0]                   target_next;
  logic [W-1:0]                   step_next;
  logic                           ramp_up;
  logic [W-1:0]                   gap;
  logic [W-1:0]                   ramp_next;

  tfrl_cfg #(.ANGLE_BITS(ANGLE_BITS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  tfrl_mul u_mul (
    .clk     (clk),
    .op_a    (op_a),
    .op_b    (op_b),
    .product (product)
  );

  assign jl = regs.jump_limit[ANGLE_BITS-1:0];
  assign af = regs.angle_floor[ANGLE_BITS-1:0];
  assign ac = regs.angle_ceiling[ANGLE_BITS-1:0];

  // handshakes
  assign tick.ready = (state == S_IDLE);
  assign in_fire    = tick.valid && tick.ready;
  assign in_active  = in_fire && !tick.output_off && !tick.fault_active;
  assign out_free   = !out_valid || cmd.ready;
  assign cmd.valid  = out_valid;
  assign cmd.duty   = out_duty;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_active) state_next = S_JUMP;
      S_JUMP:  state_next = S_CLAMP;
      S_CLAMP: state_next = S_MAP;
      S_MAP:   state_next = S_RATE;
      S_RATE:  state_next = S_STEP;
      S_STEP:  state_next = S_RAMP;
      S_RAMP:  state_next = S_DUTY;
      S_DUTY:  state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      angle_q <= tick.angle;
      trig_q  <= tick.trigger_held;
      ms_q    <= tick.elapsed_ms;
    end
  end

  // jump rejection against the held angle
  assign ref_angle = angle_seen ? held_angle : angle_q;
  assign diff      = (angle_q > ref_angle) ? angle_q - ref_angle : ref_angle - angle_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_angle <= '0;
      angle_seen <= 1'b0;
    end else if (state == S_JUMP) begin
      angle_seen <= 1'b1;
      if (diff <= jl) begin
        held_angle <= angle_q;
      end else begin
        held_angle <= ref_angle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_JUMP) begin
      angle_sel <= (diff > jl) ? ref_angle : angle_q;
    end
  end

  // clamp, ceiling first so the floor wins when they cross
  assign clamp_hi = (angle_sel > ac) ? ac : angle_sel;
  assign clamp_lo = (clamp_hi < af) ? af : clamp_hi;

  always_ff @(posedge clk) begin
    if (state == S_CLAMP) begin
      span <= clamp_lo - af;
    end
  end

  // shared multiplier operands
  always_comb begin
    case (state)
      S_MAP: begin
        op_a = W'(span);
        op_b = regs.map_gain;
      end
      S_RATE: begin
        op_a = W'(ms_q);
        op_b = trig_q ? regs.rise_rate : regs.fall_rate;
      end
      default: begin
        op_a = ramp_speed;
        op_b = regs.duty_limit;
      end
    endcase
  end

  // target speed from the map product
  assign map_sum     = 25'(regs.speed_floor) + 25'(product[tfrl_pkg::PROD_W-1:8]);
  assign target_next = !trig_q ? '0 : (|map_sum[24:16]) ? '1 : map_sum[15:0];

  always_ff @(posedge clk) begin
    if (state == S_RATE) begin
      target <= target_next;
    end
  end

  // ramp step from the rate product
  assign step_next = (|product[31:24]) ? '1 : product[23:8];

  always_ff @(posedge clk) begin
    if (state == S_STEP) begin
      step <= step_next;
    end
  end

  // move the ramp toward the target without passing it
  assign ramp_up   = ramp_speed < target;
  assign gap       = ramp_up ? target - ramp_speed : ramp_speed - target;
  assign ramp_next = (gap > step) ? (ramp_up ? ramp_speed + step : ramp_speed - step)
                                  : target;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_speed <= '0;
    end else if (state == S_RAMP) begin
      ramp_speed <= ramp_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (cmd.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_duty <= product[31:16];
    end
  end

  // checks
  a_skip_no_work: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (tick.output_off || tick.fault_active)) |=> (state == S_IDLE))
    else $error("skipped item started the sequencer");

  a_active_starts: assert property (@(posedge clk) disable iff (rst)
    in_active |=> (state == S_JUMP))
    else $error("active item did not start the sequencer");

  a_result_value: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && out_duty == $past(product[31:16])))
    else $error("result register not loaded from the duty product");

  a_ramp_only_in_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_RAMP) |=> $stable(ramp_speed))
    else $error("ramp speed changed outside the ramp step");

endmodule
